// ===== src/rkd_pkg.sv =====
// Shared types, constants and the base encoder for the repeated k-mer detector.
`default_nettype none
package rkd_pkg;

  // k-mer geometry
  localparam int KMER_LEN    = 10;
  localparam int KMER_BITS   = 2 * KMER_LEN;
  localparam int TABLE_DEPTH = 1 << KMER_BITS;
  localparam int FILL_W      = $clog2(KMER_LEN + 1);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // sighting counter saturates here
  localparam logic [1:0] COUNT_SAT = 2'd2;

  // input mode codes
  localparam logic MODE_SYMBOL = 1'b0;
  localparam logic MODE_NEW    = 1'b1;

  // ASCII characters with codes of their own
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_C = 8'h43;

  typedef enum logic [1:0] {
    CODE_A = 2'd0,
    CODE_G = 2'd1,
    CODE_C = 2'd2,
    CODE_T = 2'd3
  } base_code_t;

  typedef logic [KMER_BITS-1:0] kmer_t;

  // one command from front to back
  typedef struct packed {
    logic  clear;
    kmer_t kmer;
  } cmd_t;

  // back end sequencer states
  typedef enum logic {
    BK_CLEAR = 1'b0,
    BK_RUN   = 1'b1
  } back_state_t;

  // anything other than A, G or C counts as T
  function automatic base_code_t code_of(input logic [7:0] ch);
    base_code_t c;
    case (ch)
      CHAR_A:  c = CODE_A;
      CHAR_G:  c = CODE_G;
      CHAR_C:  c = CODE_C;
      default: c = CODE_T;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/rkd_queue.sv =====
// Small FIFO that carries commands from the front to the back.
`default_nettype none
module rkd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rkd_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output rkd_pkg::cmd_t      head,
  output logic               full,
  output logic               empty
);

  rkd_pkg::cmd_t                entries [rkd_pkg::QUEUE_DEPTH];
  logic [rkd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rkd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rkd_pkg::QCNT_W-1:0]   count;

  function automatic logic [rkd_pkg::QPTR_W-1:0] ptr_inc(
    input logic [rkd_pkg::QPTR_W-1:0] p
  );
    logic [rkd_pkg::QPTR_W-1:0] n;
    if (p == rkd_pkg::QPTR_W'(rkd_pkg::QUEUE_DEPTH - 1)) n = '0;
    else n = p + 1'b1;
    return n;
  endfunction

  assign full  = (count == rkd_pkg::QCNT_W'(rkd_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/rkd_front.sv =====
// Front end: accepts items, keeps the sliding window and issues commands.
`default_nettype none
module rkd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          mode,
  input  wire logic [7:0]    symbol,
  input  wire logic          q_full,
  output logic               push,
  output rkd_pkg::cmd_t      push_cmd
);

  rkd_pkg::kmer_t              window;
  rkd_pkg::kmer_t              window_next;
  logic [rkd_pkg::FILL_W-1:0]  fill_count;
  logic [rkd_pkg::FILL_W-1:0]  fill_next;
  logic                        accept;
  logic                        is_new;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_new   = (mode == rkd_pkg::MODE_NEW);

  // shift in the new code, count up to a full window
  always_comb begin
    window_next = (window << 2) | rkd_pkg::kmer_t'(rkd_pkg::code_of(symbol));
    if (fill_count < rkd_pkg::FILL_W'(rkd_pkg::KMER_LEN)) fill_next = fill_count + 1'b1;
    else fill_next = fill_count;
  end

  // command to the back: a clear, or a lookup once the window is full
  always_comb begin
    push           = accept &&
                     (is_new || (fill_next == rkd_pkg::FILL_W'(rkd_pkg::KMER_LEN)));
    push_cmd.clear = is_new;
    push_cmd.kmer  = window_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      fill_count <= '0;
    end else if (accept) begin
      if (is_new) begin
        window     <= '0;
        fill_count <= '0;
      end else begin
        window     <= window_next;
        fill_count <= fill_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/rkd_back.sv =====
// Back end: counter table read-modify-write, table sweep and result register.
`default_nettype none
module rkd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire rkd_pkg::cmd_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rkd_pkg::kmer_t     kmer
);

  rkd_pkg::back_state_t state;
  rkd_pkg::back_state_t state_next;
  rkd_pkg::kmer_t       sweep_address;
  logic                 sweep_last;

  // counter table
  logic [1:0]           table_mem [rkd_pkg::TABLE_DEPTH];
  logic                 mem_we;
  rkd_pkg::kmer_t       mem_waddr;
  logic [1:0]           mem_wdata;

  // lookup stage
  logic                 b_valid;
  rkd_pkg::kmer_t       b_kmer;
  logic [1:0]           rd_q;
  logic                 fwd;
  logic [1:0]           fwd_val;
  logic [1:0]           cur_cnt;
  logic [1:0]           cnt_next;
  logic                 emit;
  logic                 b_fire;
  logic                 pipe_free;
  logic                 issue;
  logic                 start_clr;

  assign sweep_last = (sweep_address == '1);

  // update the count, forwarding the write of the item just ahead
  always_comb begin
    cur_cnt   = fwd ? fwd_val : rd_q;
    cnt_next  = (cur_cnt == rkd_pkg::COUNT_SAT) ? cur_cnt : cur_cnt + 1'b1;
    emit      = (cur_cnt != rkd_pkg::COUNT_SAT) && (cnt_next == rkd_pkg::COUNT_SAT);
    b_fire    = b_valid && (!out_valid || out_ready);
    pipe_free = !b_valid || b_fire;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rkd_pkg::BK_CLEAR: if (sweep_last) state_next = rkd_pkg::BK_RUN;
      rkd_pkg::BK_RUN:   if (start_clr) state_next = rkd_pkg::BK_CLEAR;
      default:           state_next = rkd_pkg::BK_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    issue     = 1'b0;
    start_clr = 1'b0;
    mem_we    = b_fire;
    mem_waddr = b_kmer;
    mem_wdata = cnt_next;
    unique case (state)
      rkd_pkg::BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_address;
        mem_wdata = 2'd0;
      end
      rkd_pkg::BK_RUN: begin
        issue     = !q_empty && !q_head.clear && pipe_free;
        start_clr = !q_empty && q_head.clear && !b_valid;
      end
      default: begin
        issue     = 1'b0;
        start_clr = 1'b0;
      end
    endcase
    q_pop = issue || start_clr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rkd_pkg::BK_CLEAR;
      sweep_address <= '0;
    end else begin
      state <= state_next;
      if (state == rkd_pkg::BK_CLEAR) sweep_address <= sweep_address + 1'b1;
    end
  end

  // table port: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_q <= table_mem[q_head.kmer];
    end
  end

  // lookup stage payload and forwarding
  always_ff @(posedge clk) begin
    if (issue) begin
      b_kmer  <= q_head.kmer;
      fwd     <= b_fire && (b_kmer == q_head.kmer);
      fwd_val <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pipe_free) begin
      b_valid <= issue;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && emit) begin
      kmer <= b_kmer;
    end
  end

endmodule
`default_nettype wire

// ===== src/repeated_kmer_detector.sv =====
// Top level of the repeated k-mer detector: front, command queue and back.
//
//   channel  signals                      payload
//   in       in_valid / in_ready          mode, symbol
//   out      out_valid / out_ready        kmer
//
// Steady state, with no sweep and no output stall: one item per cycle; a lookup
// passes through the counter table as a registered read, then update and write,
// with forwarding between back-to-back lookups of the same k-mer.
// Reset and a new-sequence item start a table sweep over all 1,048,576 entries,
// one entry per cycle, set by the single write port of the table.
// The front keeps accepting during a sweep or an output stall until the
// two-entry command queue is full.
`default_nettype none
module repeated_kmer_detector (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       mode,
  input  wire logic [7:0]                 symbol,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rkd_pkg::KMER_BITS-1:0]   kmer
);

  rkd_pkg::cmd_t push_cmd;
  rkd_pkg::cmd_t q_head;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  rkd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .symbol   (symbol),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  rkd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  rkd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kmer      (kmer)
  );

endmodule
`default_nettype wire

// ===== src/rkd_checker.sv =====
// Port-level checks for the repeated k-mer detector, bound to the top level.
`default_nettype none
module rkd_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      mode,
  input wire logic [7:0]                symbol,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [rkd_pkg::KMER_BITS-1:0] kmer
);

  // a stalled input transfer keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(mode) && $stable(symbol))
    else $error("input changed while stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kmer))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // reset empties the queue, so input is open at once
  a_rst_in: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

  // a k-mer is never reported on two transfers in a row
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) ##1 (out_valid && out_ready) |-> kmer != $past(kmer))
    else $error("same k-mer reported twice in a row");

endmodule

bind repeated_kmer_detector rkd_checker u_rkd_checker (.*);
`default_nettype wire

// ===== tb/repeated_kmer_detector_tb.sv =====
// Self-checking testbench for the repeated k-mer detector: directed table, then replayed DNA.
`timescale 1ns / 1ps
module repeated_kmer_detector_tb;

  localparam int DIR_ROWS     = 26;
  localparam int RANDOM_ITEMS = 1750;
  localparam int TOTAL_ITEMS  = DIR_ROWS + RANDOM_ITEMS;
  localparam int CALM_ITEMS   = 200;
  localparam int HIST_DEPTH   = 256;
  // longest quiet stretch is one table sweep plus stalls; allow several sweeps
  localparam int WATCHDOG_LIMIT = 3 * rkd_pkg::TABLE_DEPTH;
  localparam int SETTLE_CYCLES  = 20;

  // one row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    logic           m;
    logic [7:0]     s;
    logic           typed;
    logic           hit;
    rkd_pkg::kmer_t k;
  } stim_row_t;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           mode      = rkd_pkg::MODE_SYMBOL;
  logic [7:0]     symbol    = 8'h00;
  logic           out_ready = 1'b0;
  logic           in_ready;
  logic           out_valid;
  rkd_pkg::kmer_t kmer;

  // predictor state
  rkd_pkg::kmer_t win_reg = '0;
  int             held    = 0;
  bit [1:0]       sightings [rkd_pkg::TABLE_DEPTH];

  rkd_pkg::kmer_t pending_kmers [$];
  logic [7:0]     recent_chars [$];

  bit             idle_on      = 1'b0;
  int             err_cnt      = 0;
  int             items_sent   = 0;
  int             new_seqs     = 0;
  int             results_seen = 0;
  int             stall_left   = 0;
  int unsigned    quiet_cycles = 0;
  rkd_pkg::kmer_t head_kmer;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // short window, then first sighting of all-A
    '{rkd_pkg::MODE_SYMBOL, rkd_pkg::CHAR_A, 1'b1, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, rkd_pkg::CHAR_A, 1'b1, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, rkd_pkg::CHAR_A, 1'b1, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, rkd_pkg::CHAR_A, 1'b1, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, rkd_pkg::CHAR_A, 1'b1, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, rkd_pkg::CHAR_A, 1'b1, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, rkd_pkg::CHAR_A, 1'b1, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, rkd_pkg::CHAR_A, 1'b1, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, rkd_pkg::CHAR_A, 1'b1, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, rkd_pkg::CHAR_A, 1'b1, 1'b0, 20'h00000},
    // second sighting reports, third stays quiet
    '{rkd_pkg::MODE_SYMBOL, rkd_pkg::CHAR_A, 1'b1, 1'b1, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, rkd_pkg::CHAR_A, 1'b1, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, rkd_pkg::CHAR_G, 1'b0, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, rkd_pkg::CHAR_C, 1'b0, 1'b0, 20'h00000},
    // ten characters that all count as T (lower case, 'T', extremes)
    '{rkd_pkg::MODE_SYMBOL, 8'hFF,  1'b0, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, 8'h00,  1'b0, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, 8'h74,  1'b0, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, 8'h80,  1'b0, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, 8'h54,  1'b0, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, 8'h7F,  1'b0, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, 8'h61,  1'b0, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, 8'h67,  1'b0, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, 8'hFE,  1'b0, 1'b0, 20'h00000},
    '{rkd_pkg::MODE_SYMBOL, 8'h01,  1'b0, 1'b0, 20'h00000},
    // 'Z' repeats the all-T k-mer
    '{rkd_pkg::MODE_SYMBOL, 8'h5A,  1'b1, 1'b1, 20'hFFFFF},
    // new sequence, symbol ignored
    '{rkd_pkg::MODE_NEW,    8'hFF,  1'b1, 1'b0, 20'h00000}
  };

  repeated_kmer_detector uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .symbol    (symbol),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kmer      (kmer)
  );

  always #5 clk = ~clk;

  function automatic bit is_t_class(input logic [7:0] c);
    return (c != rkd_pkg::CHAR_A) && (c != rkd_pkg::CHAR_G) && (c != rkd_pkg::CHAR_C);
  endfunction

  // advance the predicted window and sighting counters by one item
  task automatic track_kmer(input logic m, input logic [7:0] s,
                            output bit hit, output rkd_pkg::kmer_t k);
    rkd_pkg::base_code_t b;
    hit = 1'b0;
    k   = '0;
    if (m == rkd_pkg::MODE_NEW) begin
      win_reg = '0;
      held    = 0;
      foreach (sightings[i]) sightings[i] = 2'd0;
    end else begin
      case (s)
        rkd_pkg::CHAR_A: b = rkd_pkg::CODE_A;
        rkd_pkg::CHAR_G: b = rkd_pkg::CODE_G;
        rkd_pkg::CHAR_C: b = rkd_pkg::CODE_C;
        default:         b = rkd_pkg::CODE_T;
      endcase
      win_reg = {win_reg[rkd_pkg::KMER_BITS-3:0], b};
      if (held < rkd_pkg::KMER_LEN) held++;
      if (held == rkd_pkg::KMER_LEN && sightings[win_reg] < rkd_pkg::COUNT_SAT) begin
        sightings[win_reg]++;
        if (sightings[win_reg] == rkd_pkg::COUNT_SAT) begin
          hit = 1'b1;
          k   = win_reg;
        end
      end
    end
  endtask

  // one input transfer; valid stays high afterward unless the next call idles
  task automatic feed_item(input logic m, input logic [7:0] s, input bit typed,
                           input bit typed_hit, input rkd_pkg::kmer_t typed_k);
    int             gap;
    bit             hit;
    rkd_pkg::kmer_t k;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    symbol   <= s;
    do @(posedge clk); while (!in_ready);
    track_kmer(m, s, hit, k);
    if (typed) begin
      hit = typed_hit;
      k   = typed_k;
    end
    if (hit) pending_kmers = {pending_kmers, k};
    if (m == rkd_pkg::MODE_NEW) new_seqs++;
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    feed_item(rkd_pkg::MODE_SYMBOL, c, 1'b0, 1'b0, '0);
    recent_chars = {recent_chars, c};
    if (recent_chars.size() > HIST_DEPTH) void'(recent_chars.pop_front());
  endtask

  // hold the sender off until every predicted k-mer has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_kmers.size() != 0);
  endtask

  // output side: check each transfer, stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_kmers.size() == 0) begin
          err_cnt++;
          $display("%0t: kmer expected none, actual %05h", $time, kmer);
        end else begin
          head_kmer = pending_kmers.pop_front();
          results_seen++;
          if (kmer !== head_kmer) begin
            err_cnt++;
            $display("%0t: kmer expected %05h, actual %05h", $time, head_kmer, kmer);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        stall_left <= $urandom_range(0, 17);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
      $display("repeated_kmer_detector test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int         kind;
    int         len;
    int         start;
    int         phase_mark;
    bit         cleared_mid;
    logic [7:0] c;
    logic [7:0] seg [$];

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, idling on
    idle_on = 1'b1;
    foreach (dir_rows[i])
      feed_item(dir_rows[i].m, dir_rows[i].s, dir_rows[i].typed, dir_rows[i].hit,
                dir_rows[i].k);
    drain_results();

    // random part: mostly replays of recent stretches so k-mers recur
    phase_mark  = items_sent;
    cleared_mid = 1'b0;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= phase_mark) begin
        phase_mark += 100;
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (items_sent >= TOTAL_ITEMS - CALM_ITEMS) idle_on = 1'b0;

      // one new sequence midway, after the pipeline has drained
      if (!cleared_mid && items_sent >= DIR_ROWS + RANDOM_ITEMS / 2) begin
        drain_results();
        feed_item(rkd_pkg::MODE_NEW, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        recent_chars.delete();
        cleared_mid = 1'b1;
      end

      kind = $urandom_range(0, 9);
      seg.delete();
      if (kind <= 5 && recent_chars.size() >= rkd_pkg::KMER_LEN) begin
        len = $urandom_range(rkd_pkg::KMER_LEN, 2 * rkd_pkg::KMER_LEN + 4);
        if (len > recent_chars.size()) len = recent_chars.size();
        start = $urandom_range(0, recent_chars.size() - len);
        for (int i = 0; i < len; i++) seg = {seg, recent_chars[start + i]};
        foreach (seg[i]) begin
          c = seg[i];
          // swap in another T-class character now and then
          if (is_t_class(c) && $urandom_range(0, 1) == 1)
            do c = 8'($urandom_range(0, 255)); while (!is_t_class(c));
          send_char(c);
        end
      end else if (kind <= 8) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 8))
            0, 1:    c = rkd_pkg::CHAR_A;
            2, 3:    c = rkd_pkg::CHAR_G;
            4, 5:    c = rkd_pkg::CHAR_C;
            6, 7:    c = 8'h54;
            default: c = 8'($urandom_range(0, 255));
          endcase
          send_char(c);
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) send_char(8'($urandom_range(0, 255)));
      end
    end

    // wait for the tail, then a few idle cycles for stray outputs
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items, %0d of them new-sequence commands,", items_sent, new_seqs);
    $display("and checked %0d repeated k-mers under random input and output stalls",
             results_seen);
    if (err_cnt == 0) begin
      $display("repeated_kmer_detector test passed");
    end else begin
      $display("repeated_kmer_detector test failed");
    end
    $finish;
  end

endmodule
